// ===== rtl/amm_pkg.sv =====
// Shared types and constants for the audio matrix mixer.
// Used by every module of the mixer; depends on nothing else.
`default_nettype none
package amm_pkg;
   localparam int MaxInputsDefault  = 8;
   localparam int MaxOutputsDefault = 8;
   localparam int AccCount          = 8;
   localparam int MaxLog2           = 10;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_GAIN   = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   typedef struct packed {
      logic signed [19:0] gain_cur;
      logic signed [19:0] gain_old;
   } gain_pair_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] oidx;
   } mac_op_type;
endpackage
`default_nettype wire

// ===== rtl/amm_gain_mem.sv =====
// Gain matrix memory holding the current and ramp-start gain of each pair.
// Uses the pair type from amm_pkg.
`default_nettype none
module amm_gain_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire                   clock,
   input  wire                   rd_en,
   input  wire [AW-1:0]          rd_addr,
   output amm_pkg::gain_pair_type rd_data,
   input  wire                   wr_en,
   input  wire [AW-1:0]          wr_addr,
   input  amm_pkg::gain_pair_type wr_data
);
   amm_pkg::gain_pair_type mem_ff [DEPTH];
   amm_pkg::gain_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== rtl/amm_mac.sv =====
// Gain ramp, multiply and accumulate pipeline with the output accumulators.
// Uses types from amm_pkg; fed by the gain memory read data.
`default_nettype none
module amm_mac (
   input  wire                    clock,
   input  wire                    reset,
   input  amm_pkg::mac_op_type    op_in,
   input  amm_pkg::gain_pair_type gain,
   input  wire signed [23:0]      sample,
   input  wire                    interp,
   input  wire [10:0]             factor,
   input  wire [3:0]              shift,
   input  wire                    clear_all,
   input  wire [2:0]              rd_idx,
   output logic signed [23:0]     rd_result,
   output logic                   busy
);
   amm_pkg::mac_op_type op_a_ff;
   logic              b_v_ff, b_v_in, c_v_ff, d_v_ff;
   logic [2:0]        b_o_ff, c_o_ff, d_o_ff;
   logic signed [32:0] b_prod_ff, b_prod_in;
   logic signed [19:0] b_cur_ff, b_old_ff;
   logic signed [20:0] diff, c_g_ff, c_g_in;
   logic signed [32:0] shifted, g_full;
   logic signed [44:0] d_p_ff, d_p_in;
   logic signed [47:0] acc_ff [amm_pkg::AccCount];
   logic signed [48:0] sum, rnd;
   logic signed [47:0] sum_sat;
   logic signed [32:0] rnd_hi;

   always_comb begin
      diff = {gain.gain_cur[19], gain.gain_cur} - {gain.gain_old[19], gain.gain_old};
      b_prod_in = 33'(diff) * 33'($signed({1'b0, factor}));
      b_v_in = op_a_ff.valid && (gain.gain_cur != 20'sd0);
      shifted = b_prod_ff >>> shift;
      g_full = 33'(b_old_ff) + shifted;
      c_g_in = interp ? g_full[20:0] : 21'(b_cur_ff);
      d_p_in = 45'(c_g_ff) * 45'(sample);
      sum = 49'(acc_ff[d_o_ff]) + 49'(d_p_ff);
      if (sum[48] != sum[47]) begin
         sum_sat = sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         sum_sat = sum[47:0];
      end
      rnd = 49'(acc_ff[rd_idx]) + 49'sd32768;
      rnd_hi = rnd[48:16];
      if (rnd_hi > 33'sd8388607) begin
         rd_result = 24'sh7FFFFF;
      end else if (rnd_hi < -33'sd8388608) begin
         rd_result = 24'sh800000;
      end else begin
         rd_result = rnd_hi[23:0];
      end
      busy = op_a_ff.valid || b_v_ff || c_v_ff || d_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_a_ff <= '0;
         b_v_ff  <= 1'b0;
         c_v_ff  <= 1'b0;
         d_v_ff  <= 1'b0;
         for (int i = 0; i < amm_pkg::AccCount; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         op_a_ff <= op_in;
         b_v_ff  <= b_v_in;
         c_v_ff  <= b_v_ff;
         d_v_ff  <= c_v_ff;
         if (clear_all) begin
            for (int i = 0; i < amm_pkg::AccCount; i++) begin
               acc_ff[i] <= '0;
            end
         end else if (d_v_ff) begin
            acc_ff[d_o_ff] <= sum_sat;
         end
      end
      b_o_ff    <= op_a_ff.oidx;
      b_prod_ff <= b_prod_in;
      b_cur_ff  <= gain.gain_cur;
      b_old_ff  <= gain.gain_old;
      c_o_ff    <= b_o_ff;
      c_g_ff    <= c_g_in;
      d_o_ff    <= c_o_ff;
      d_p_ff    <= d_p_in;
   end
endmodule
`default_nettype wire

// ===== rtl/audio_matrix_mixer.sv =====
// Audio matrix mixer: a sample request issues one gain memory read per active output and
// waits for the MAC pipeline to drain; on a frame end it then emits and clears the
// accumulators. A gain write reads the gain pair and then writes it, a clear request
// zeroes the whole gain memory, and a vector end in ramp mode adds a copy pass over it.
// After reset a clearing pass over the whole gain memory runs before requests are taken.
`default_nettype none
module audio_matrix_mixer #(
   parameter int MAX_INPUTS  = amm_pkg::MaxInputsDefault,
   parameter int MAX_OUTPUTS = amm_pkg::MaxOutputsDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // in_channel[2:0], out_channel[5:3], sample_in[29:6], gain_value[49:30], zero fill
   input  wire  [55:0] req_tdata,
   // kind[1:0]
   input  wire  [1:0]  req_tuser,
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // out_index[2:0], sample_out[26:3], zero fill
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [3:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int Depth = MAX_INPUTS * MAX_OUTPUTS;
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int OutCap = (MAX_OUTPUTS < amm_pkg::AccCount) ? MAX_OUTPUTS : amm_pkg::AccCount;
   localparam logic [1:0] REG_OUTPUTS = 2'd0;
   localparam logic [1:0] REG_INTERP  = 2'd1;
   localparam logic [1:0] REG_VLOG    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_GAIN_RD, ST_GAIN_WR, ST_ISSUE, ST_DRAIN,
      ST_EMIT, ST_FRAME_DONE, ST_SYNC, ST_SYNC_LAST
   } state_type;

   state_type state_ff;
   logic [AW-1:0] cnt_ff, sync_addr_ff;
   logic          sync_pend_ff;
   logic [3:0]    o_ff, n_ff;
   logic [2:0]    ic_ff, oc_ff;
   logic signed [23:0] s_ff;
   logic signed [19:0] gv_ff;
   logic          fend_ff;
   logic [9:0]    fpos_ff;
   logic [3:0]    num_out_ff, vlog_ff;
   logic          interp_ff;
   logic          rsp_v_ff, rsp_last_ff;
   logic [2:0]    rsp_idx_ff;
   logic signed [23:0] rsp_s_ff;

   logic [3:0]    n_eff, lg;
   logic [10:0]   vlen, fp1, factor;
   logic          wrap, ic_ok, gain_ok, accept, cfg_wr;
   logic          mem_rd_en, mem_wr_en, mac_busy, mac_clear;
   logic [AW-1:0] mem_rd_addr, mem_wr_addr, issue_addr, gain_addr;
   amm_pkg::gain_pair_type mem_rd_data, mem_wr_data;
   amm_pkg::mac_op_type    mac_op;
   logic signed [23:0] mac_result;

   always_comb begin
      n_eff = (num_out_ff > 4'(OutCap)) ? 4'(OutCap) : num_out_ff;
      lg = (vlog_ff > 4'(amm_pkg::MaxLog2)) ? 4'(amm_pkg::MaxLog2) : vlog_ff;
      vlen = 11'd1 << lg;
      fp1 = {1'b0, fpos_ff} + 11'd1;
      wrap = fp1 >= vlen;
      factor = (fp1 > vlen) ? vlen : fp1;
      ic_ok = int'(ic_ff) < MAX_INPUTS;
      gain_ok = ic_ok && (int'(oc_ff) < MAX_OUTPUTS);
      issue_addr = AW'(int'(ic_ff) * MAX_OUTPUTS + int'(o_ff));
      gain_addr = AW'(int'(ic_ff) * MAX_OUTPUTS + int'(oc_ff));
      accept = req_tvalid && req_tready;
      cfg_wr = csr_psel && csr_penable && csr_pwrite;
      mem_rd_en = 1'b0;
      mem_rd_addr = cnt_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = sync_addr_ff;
      mem_wr_data = '{gain_cur: mem_rd_data.gain_cur, gain_old: mem_rd_data.gain_cur};
      mac_op = '{valid: 1'b0, oidx: o_ff[2:0]};
      mac_clear = state_ff == ST_FRAME_DONE;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = '0;
         end
         ST_GAIN_RD: begin
            mem_rd_en = 1'b1;
            mem_rd_addr = gain_addr;
         end
         ST_GAIN_WR: begin
            mem_wr_en = 1'b1;
            mem_wr_addr = gain_addr;
            mem_wr_data = '{gain_cur: gv_ff, gain_old: mem_rd_data.gain_cur};
         end
         ST_ISSUE: begin
            mem_rd_en = 1'b1;
            mem_rd_addr = issue_addr;
            mac_op.valid = ic_ok && (n_ff != 4'd0);
         end
         ST_SYNC: begin
            mem_rd_en = 1'b1;
            mem_wr_en = sync_pend_ff;
         end
         ST_SYNC_LAST: mem_wr_en = sync_pend_ff;
         default: ;
      endcase
      req_tready = state_ff == ST_IDLE;
      rsp_tvalid = rsp_v_ff;
      rsp_tdata = {5'd0, rsp_s_ff, rsp_idx_ff};
      rsp_tlast = rsp_last_ff;
      csr_pready = 1'b1;
      unique case (csr_paddr[3:2])
         REG_OUTPUTS: csr_prdata = {28'd0, num_out_ff};
         REG_INTERP:  csr_prdata = {31'd0, interp_ff};
         REG_VLOG:    csr_prdata = {28'd0, vlog_ff};
         default:     csr_prdata = '0;
      endcase
   end

   amm_gain_mem #(.DEPTH(Depth), .AW(AW)) u_gain_mem (
      .clock(clock), .rd_en(mem_rd_en), .rd_addr(mem_rd_addr), .rd_data(mem_rd_data),
      .wr_en(mem_wr_en), .wr_addr(mem_wr_addr), .wr_data(mem_wr_data)
   );

   amm_mac u_mac (
      .clock(clock), .reset(reset), .op_in(mac_op), .gain(mem_rd_data), .sample(s_ff),
      .interp(interp_ff), .factor(factor), .shift(lg), .clear_all(mac_clear),
      .rd_idx(o_ff[2:0]), .rd_result(mac_result), .busy(mac_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         sync_pend_ff <= 1'b0;
         o_ff         <= '0;
         fpos_ff      <= '0;
         num_out_ff   <= 4'd2;
         interp_ff    <= 1'b0;
         vlog_ff      <= 4'd6;
         rsp_v_ff     <= 1'b0;
      end else begin
         if (cfg_wr) begin
            unique case (csr_paddr[3:2])
               REG_OUTPUTS: num_out_ff <= csr_pwdata[3:0];
               REG_INTERP:  interp_ff  <= csr_pwdata[0];
               REG_VLOG:    vlog_ff    <= csr_pwdata[3:0];
               default: ;
            endcase
         end
         if (rsp_v_ff && rsp_tready && state_ff != ST_EMIT) begin
            rsp_v_ff <= 1'b0;
         end
         sync_pend_ff <= state_ff == ST_SYNC;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  ic_ff   <= req_tdata[2:0];
                  oc_ff   <= req_tdata[5:3];
                  s_ff    <= req_tdata[29:6];
                  gv_ff   <= req_tdata[49:30];
                  fend_ff <= req_tlast;
                  n_ff    <= n_eff;
                  o_ff    <= '0;
                  cnt_ff  <= '0;
                  case (req_tuser)
                     amm_pkg::KIND_SAMPLE: state_ff <= ST_ISSUE;
                     amm_pkg::KIND_GAIN:   state_ff <= ST_GAIN_RD;
                     amm_pkg::KIND_CLEAR:  state_ff <= ST_CLEAR;
                     default:              state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == AW'(Depth - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_GAIN_RD: state_ff <= gain_ok ? ST_GAIN_WR : ST_IDLE;
            ST_GAIN_WR: state_ff <= ST_IDLE;
            ST_ISSUE: begin
               if (!ic_ok || n_ff == 4'd0) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  o_ff <= o_ff + 4'd1;
                  if (o_ff + 4'd1 == n_ff) begin
                     state_ff <= ST_DRAIN;
                  end
               end
            end
            ST_DRAIN: begin
               if (!mac_busy) begin
                  o_ff <= '0;
                  if (!fend_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= (n_ff == 4'd0) ? ST_FRAME_DONE : ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (!rsp_v_ff || rsp_tready) begin
                  rsp_v_ff    <= 1'b1;
                  rsp_idx_ff  <= o_ff[2:0];
                  rsp_s_ff    <= mac_result;
                  rsp_last_ff <= o_ff + 4'd1 == n_ff;
                  o_ff        <= o_ff + 4'd1;
                  if (o_ff + 4'd1 == n_ff) begin
                     state_ff <= ST_FRAME_DONE;
                  end
               end
            end
            ST_FRAME_DONE: begin
               cnt_ff <= '0;
               if (wrap) begin
                  fpos_ff  <= '0;
                  state_ff <= interp_ff ? ST_SYNC : ST_IDLE;
               end else begin
                  fpos_ff  <= fp1[9:0];
                  state_ff <= ST_IDLE;
               end
            end
            ST_SYNC: begin
               sync_addr_ff <= cnt_ff;
               cnt_ff       <= cnt_ff + 1'b1;
               if (cnt_ff == AW'(Depth - 1)) begin
                  state_ff <= ST_SYNC_LAST;
               end
            end
            ST_SYNC_LAST: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_ready_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mac_busy)
      else $error("request taken while the MAC pipeline still runs");
   a_no_wr_during_issue: assert property (@(posedge clock) disable iff (reset)
      mac_op.valid |-> !mem_wr_en)
      else $error("gain memory written during a sample issue");
   a_last_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_v_ff && rsp_last_ff) |-> (4'(rsp_idx_ff) + 4'd1 == n_ff))
      else $error("last marker on the wrong output channel");
   a_reset_clears_first: assert property (@(posedge clock)
      $past(reset) && !reset |-> !req_tready)
      else $error("request accepted before the clearing pass");
endmodule
`default_nettype wire
